### sv/adpcm_pkg.sv
// ----------------------------------------------------------------------------
// ADPCM encoder package
// Shared types, the IMA step table and the index adaptation table.
// ----------------------------------------------------------------------------
package adpcm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int IDX_W    = 7;
    localparam int STEP_W   = 15;
    localparam int CODE_W   = 4;
    localparam int BYTE_W   = 8;

    localparam logic [IDX_W-1:0] IDX_MAX = 7'd88;

    localparam logic signed [17:0] PRED_MAX = 18'sd32767;
    localparam logic signed [17:0] PRED_MIN = -18'sd32767;

    // One kept sample on its way from the front end to the encoder.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       second;  // completes a pair, a byte goes out
    } item_t;

    localparam logic [STEP_W-1:0] STEP_TABLE [0:88] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,
        15'd13,    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,
        15'd23,    15'd25,    15'd28,    15'd31,    15'd34,    15'd37,
        15'd41,    15'd45,    15'd50,    15'd55,    15'd60,    15'd66,
        15'd73,    15'd80,    15'd88,    15'd97,    15'd107,   15'd118,
        15'd130,   15'd143,   15'd157,   15'd173,   15'd190,   15'd209,
        15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
        15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,
        15'd724,   15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,
        15'd1282,  15'd1411,  15'd1552,  15'd1707,  15'd1878,  15'd2066,
        15'd2272,  15'd2499,  15'd2749,  15'd3024,  15'd3327,  15'd3660,
        15'd4026,  15'd4428,  15'd4871,  15'd5358,  15'd5894,  15'd6484,
        15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442, 15'd11487,
        15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
        15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    localparam logic signed [4:0] INDEX_ADJUST [0:7] = '{
        -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
    };

endpackage

### sv/adpcm_encoder_packer.sv
// ----------------------------------------------------------------------------
// IMA ADPCM encoder with nibble packer
// Encodes 16-bit PCM samples to 4-bit codes and emits two codes per byte.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                       Handshake
//   s_*       in         tdata[15:0] audio_sample      tvalid / tready
//   m_*       out        tdata[7:0]  packed_byte       tvalid / tready
//   cfg_*     in         wr_data     decimate_mode     wr_en, no wait
//
// The block takes one sample request per cycle while the queue has room.
// A kept sample enters the queue and reaches the encoder from its head, and
// a completed byte is registered and shows on m_tvalid. The quantizer and
// predictor update in the back end are combinational and set the rate. Reset
// clears the predictor, the step index, the held code, the sample phase and
// the mode. An output stall only holds back samples that complete a byte;
// the queue absorbs the rest, and s_tready drops only when the queue is full.
//
// The front end keeps the phase within each group of four samples. In normal
// mode every sample is encoded and odd phases complete a byte; in decimating
// mode phases one and three are dropped and phase two completes the byte.
// The first code of a pair sits in bits 3:0 of the byte, the second in 7:4.
// ----------------------------------------------------------------------------
module adpcm_encoder_packer
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // decimate_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // [15:0] audio_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata        // [7:0] packed_byte
);

    logic             q_ready;
    logic             q_push;
    adpcm_pkg::item_t q_item;
    logic             q_pop;
    logic             head_valid;
    adpcm_pkg::item_t head_item;

    // Front end: mode register, phase counter and keep/complete decision.
    adpcm_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .q_ready     (q_ready),
        .q_push      (q_push),
        .q_item      (q_item)
    );

    // Queue of kept samples so the front end keeps accepting during a stall.
    adpcm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_item),
        .ready      (q_ready),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Back end: quantizer, predictor and index update, byte packing.
    adpcm_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

### sv/adpcm_front.sv
// ----------------------------------------------------------------------------
// ADPCM front end
// Holds the mode register and the sample phase, and decides for each
// request whether it is dropped, held as the first code or completes a byte.
// ----------------------------------------------------------------------------
module adpcm_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [adpcm_pkg::SAMPLE_W-1:0] s_tdata,
    input  logic                          q_ready,
    output logic                          q_push,
    output adpcm_pkg::item_t              q_item
);

    logic       decimate_reg;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic       accept;
    logic       keep;

    assign s_tready = q_ready;
    assign accept   = s_tvalid && q_ready;

    always_comb
    begin
        if (decimate_reg)
        begin
            keep          = !phase_reg[0];
            q_item.second = phase_reg[1] && !phase_reg[0];
        end
        else
        begin
            keep          = 1'b1;
            q_item.second = phase_reg[0];
        end
        q_item.sample = s_tdata;
        q_push        = accept && keep;
        phase_next    = accept ? phase_reg + 2'd1 : phase_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decimate_reg <= 1'b0;
            phase_reg    <= 2'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                decimate_reg <= cfg_wr_data;
            end
            phase_reg <= phase_next;
        end
    end

endmodule

### sv/adpcm_queue.sv
// ----------------------------------------------------------------------------
// ADPCM item queue
// Small first-in first-out queue between the front end and the encoder.
// ----------------------------------------------------------------------------
module adpcm_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  adpcm_pkg::item_t push_item,
    output logic             ready,
    input  logic             pop,
    output logic             head_valid,
    output adpcm_pkg::item_t head_item
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    adpcm_pkg::item_t  slot_reg [0:DEPTH-1];
    logic [ADDR_W-1:0] wr_ptr_reg;
    logic [ADDR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign ready      = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign do_push    = push && ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### sv/adpcm_back.sv
// ----------------------------------------------------------------------------
// ADPCM back end
// Quantizes one kept sample per cycle while the output register can take
// a byte, updates predictor and step index and packs code pairs into it.
// ----------------------------------------------------------------------------
module adpcm_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        head_valid,
    input  adpcm_pkg::item_t            head_item,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [adpcm_pkg::BYTE_W-1:0] m_tdata
);

    logic signed [15:0] pred_reg;
    logic signed [15:0] pred_next;
    logic [6:0]         index_reg;
    logic [6:0]         index_next;
    logic [3:0]         held_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [7:0]         out_data_reg;

    logic [6:0]         idx_lim;
    logic [16:0]        step0;
    logic [16:0]        step1;
    logic [16:0]        step2;
    logic signed [16:0] diff;
    logic [16:0]        mag0;
    logic [16:0]        mag1;
    logic [16:0]        mag2;
    logic [16:0]        dq0;
    logic [16:0]        dq1;
    logic [16:0]        dq2;
    logic [16:0]        dq3;
    logic [3:0]         code;
    logic signed [17:0] sum;
    logic signed [7:0]  nidx;

    // A held first code never needs the output slot, a pair completion does.
    assign pop = head_valid && (!head_item.second || !out_valid_reg || m_tready);

    always_comb
    begin
        idx_lim = (index_reg > adpcm_pkg::IDX_MAX) ? adpcm_pkg::IDX_MAX : index_reg;
        step0   = {2'b00, adpcm_pkg::STEP_TABLE[idx_lim]};
        diff    = {head_item.sample[15], head_item.sample} - {pred_reg[15], pred_reg};
        code[3] = diff[16];
        mag0    = diff[16] ? 17'(-diff) : 17'(diff);
        dq0     = step0 >> 3;

        code[2] = (mag0 >= step0);
        mag1    = code[2] ? mag0 - step0 : mag0;
        dq1     = code[2] ? dq0 + step0 : dq0;

        step1   = step0 >> 1;
        code[1] = (mag1 >= step1);
        mag2    = code[1] ? mag1 - step1 : mag1;
        dq2     = code[1] ? dq1 + step1 : dq1;

        step2   = step1 >> 1;
        code[0] = (mag2 >= step2);
        dq3     = code[0] ? dq2 + step2 : dq2;

        sum = code[3] ? {{2{pred_reg[15]}}, pred_reg} - $signed({1'b0, dq3})
                      : {{2{pred_reg[15]}}, pred_reg} + $signed({1'b0, dq3});
        if (sum > adpcm_pkg::PRED_MAX)
        begin
            pred_next = 16'(adpcm_pkg::PRED_MAX);
        end
        else if (sum < adpcm_pkg::PRED_MIN)
        begin
            pred_next = 16'(adpcm_pkg::PRED_MIN);
        end
        else
        begin
            pred_next = sum[15:0];
        end

        nidx = $signed({1'b0, idx_lim})
             + {{3{adpcm_pkg::INDEX_ADJUST[code[2:0]][4]}}, adpcm_pkg::INDEX_ADJUST[code[2:0]]};
        if (nidx < 8'sd0)
        begin
            index_next = 7'd0;
        end
        else if (nidx > $signed({1'b0, adpcm_pkg::IDX_MAX}))
        begin
            index_next = adpcm_pkg::IDX_MAX;
        end
        else
        begin
            index_next = nidx[6:0];
        end

        if (pop && head_item.second)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg      <= '0;
            index_reg     <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                pred_reg  <= pred_next;
                index_reg <= index_next;
                if (!head_item.second)
                begin
                    held_reg <= code;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_item.second)
        begin
            out_data_reg <= {code, held_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
